/* rtl/cau_pkg.sv */
// Shared types and constants of the complex arithmetic unit.
// Holds the channel payload structs, the pipeline work record and the CORDIC angle table.
// No dependencies.
package cau_pkg;

    localparam int DATA_WIDTH      = 32;
    localparam int FRAC_BITS       = 16;
    localparam int PROD_W          = 2 * DATA_WIDTH;
    localparam int QUO_W           = DATA_WIDTH + 1;
    localparam int DIV_PRE         = QUO_W - FRAC_BITS;
    localparam int ITER_STEPS      = QUO_W;
    localparam int SQRT_STEPS      = PROD_W / 2;
    localparam int CORDIC_STEPS    = 32;
    localparam int CORDIC_PRESHIFT = 28;
    localparam int ANG_FRAC        = 32;
    localparam int ANG_W           = 41;
    localparam int ATAN_LEN        = 17;

    localparam logic [63:0] DEC_UNIT = 64'd1000000000000;

    localparam logic [ANG_W-1:0] ANG_90  = ANG_W'(90)  << ANG_FRAC;
    localparam logic [ANG_W-1:0] ANG_180 = ANG_W'(180) << ANG_FRAC;
    localparam logic [ANG_W-1:0] ANG_360 = ANG_W'(360) << ANG_FRAC;

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_MUL   = 3'd2,
        OP_DIV   = 3'd3,
        OP_POLAR = 3'd4
    } op_t;

    typedef struct packed {
        logic [2:0]                   op;
        logic signed [DATA_WIDTH-1:0] a_real;
        logic signed [DATA_WIDTH-1:0] a_imag;
        logic signed [DATA_WIDTH-1:0] b_real;
        logic signed [DATA_WIDTH-1:0] b_imag;
    } cau_in_t;

    typedef struct packed {
        logic signed [DATA_WIDTH-1:0] res_real;
        logic signed [DATA_WIDTH-1:0] res_imag;
        logic                         div_zero;
        logic                         overflow;
    } cau_out_t;

    // Everything one item carries through the iterative stages
    typedef struct packed {
        logic [2:0]                 op;
        logic signed [DATA_WIDTH:0] sum_real;
        logic signed [DATA_WIDTH:0] sum_imag;
        logic                       x_neg;
        logic                       y_neg;
        logic [PROD_W-1:0]          x_mag;
        logic [PROD_W-1:0]          y_mag;
        logic [PROD_W-1:0]          den;
        logic                       div_zero;
        logic                       x_big;
        logic                       y_big;
        logic [PROD_W-1:0]          x_rem;
        logic [PROD_W-1:0]          y_rem;
        logic [QUO_W-1:0]           x_quo;
        logic [QUO_W-1:0]           y_quo;
        logic [PROD_W-1:0]          sq_rad;
        logic [PROD_W-1:0]          sq_root;
        logic signed [PROD_W-1:0]   cx;
        logic signed [PROD_W-1:0]   cy;
        logic signed [ANG_W-1:0]    cz;
        logic                       re_neg;
        logic                       im_neg;
        logic                       re_zero;
        logic                       im_zero;
    } cau_work_t;

    // atan(2^-i) in degrees with ANG_FRAC fraction bits, evaluated at elaboration
    function automatic logic [ANG_W-2:0] atan_step(input int i);
        logic [63:0] d;
        logic [63:0] q;
        logic [63:0] r;
        int          k;
        int          b;
        k = (i < ATAN_LEN) ? i : ATAN_LEN - 1;
        case (k)
            0:       d = 64'd45000000000000;
            1:       d = 64'd26565051177078;
            2:       d = 64'd14036243467926;
            3:       d = 64'd7125016348902;
            4:       d = 64'd3576334374997;
            5:       d = 64'd1789910608246;
            6:       d = 64'd895173710211;
            7:       d = 64'd447614170861;
            8:       d = 64'd223810500369;
            9:       d = 64'd111905677066;
            10:      d = 64'd55952891894;
            11:      d = 64'd27976452617;
            12:      d = 64'd13988227142;
            13:      d = 64'd6994113675;
            14:      d = 64'd3497056851;
            15:      d = 64'd1748528427;
            default: d = 64'd874264214;
        endcase
        q = d / DEC_UNIT;
        r = d % DEC_UNIT;
        for (b = 0; b < ANG_FRAC; b++) begin
            r = r << 1;
            q = q << 1;
            if (r >= DEC_UNIT) begin
                r = r - DEC_UNIT;
                q = q | 64'd1;
            end
        end
        if (i > k) begin
            q = q >> (i - k);
        end
        return q[ANG_W-2:0];
    endfunction

    // Root bit weight of one square-root step, zero past the last step
    function automatic logic [PROD_W-1:0] sqrt_bit(input int i);
        if (i < SQRT_STEPS) begin
            return PROD_W'(1) << (PROD_W - 2 - 2 * i);
        end
        return '0;
    endfunction

endpackage

/* rtl/cau_iter.sv */
// One iteration stage: divider step for both quotients; square-root and CORDIC steps in range.
// Depends on cau_pkg.
module cau_iter
    import cau_pkg::*;
#(
    parameter int STEP = 0
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      en,
    input  logic      valid_in,
    input  cau_work_t work_in,
    output logic      valid_out,
    output cau_work_t work_out
);

    localparam int  NB_K   = QUO_W - 1 - STEP;
    localparam bit  NB_USE = (NB_K >= FRAC_BITS);
    localparam int  NB_IDX = NB_USE ? NB_K - FRAC_BITS : 0;

    localparam logic [ANG_W-2:0]  STEP_ANGLE = atan_step(STEP);
    localparam logic [PROD_W-1:0] SQRT_BIT   = sqrt_bit(STEP);

    logic      valid_reg;
    cau_work_t work_reg;
    cau_work_t work_next;

    logic [PROD_W-1:0] base_x;
    logic [PROD_W-1:0] base_y;
    logic              big_x;
    logic              big_y;
    logic [PROD_W:0]   trial_x;
    logic [PROD_W:0]   trial_y;
    logic [PROD_W:0]   diff_x;
    logic [PROD_W:0]   diff_y;
    logic              qbit_x;
    logic              qbit_y;
    logic [PROD_W:0]   sq_trial;
    logic [PROD_W:0]   sq_diff;
    logic              sq_take;
    logic signed [PROD_W-1:0] dx;
    logic signed [PROD_W-1:0] dy;
    logic signed [ANG_W-1:0]  dz;

    // Divider: seed the partial remainder on the first step, then shift in one dividend bit
    always_comb begin
        if (STEP == 0) begin
            base_x = work_in.x_mag >> DIV_PRE;
            base_y = work_in.y_mag >> DIV_PRE;
            big_x  = (work_in.x_mag >> DIV_PRE) >= work_in.den;
            big_y  = (work_in.y_mag >> DIV_PRE) >= work_in.den;
        end else begin
            base_x = work_in.x_rem;
            base_y = work_in.y_rem;
            big_x  = work_in.x_big;
            big_y  = work_in.y_big;
        end
        trial_x = {base_x, (NB_USE ? work_in.x_mag[NB_IDX] : 1'b0)};
        trial_y = {base_y, (NB_USE ? work_in.y_mag[NB_IDX] : 1'b0)};
        diff_x  = trial_x - {1'b0, work_in.den};
        diff_y  = trial_y - {1'b0, work_in.den};
        qbit_x  = (trial_x >= {1'b0, work_in.den});
        qbit_y  = (trial_y >= {1'b0, work_in.den});
    end

    // Square root and CORDIC operands
    always_comb begin
        sq_trial = {1'b0, work_in.sq_root} + {1'b0, SQRT_BIT};
        sq_diff  = {1'b0, work_in.sq_rad} - sq_trial;
        sq_take  = ({1'b0, work_in.sq_rad} >= sq_trial);
        dx       = work_in.cy >>> STEP;
        dy       = work_in.cx >>> STEP;
        dz       = $signed({1'b0, STEP_ANGLE});
    end

    // Advance all three units by one step; square root and CORDIC only within their step counts
    always_comb begin
        work_next        = work_in;
        work_next.x_big  = big_x;
        work_next.y_big  = big_y;
        work_next.x_rem  = qbit_x ? diff_x[PROD_W-1:0] : trial_x[PROD_W-1:0];
        work_next.y_rem  = qbit_y ? diff_y[PROD_W-1:0] : trial_y[PROD_W-1:0];
        work_next.x_quo  = {work_in.x_quo[QUO_W-2:0], qbit_x};
        work_next.y_quo  = {work_in.y_quo[QUO_W-2:0], qbit_y};
        if (STEP < SQRT_STEPS) begin
            if (sq_take) begin
                work_next.sq_rad  = sq_diff[PROD_W-1:0];
                work_next.sq_root = (work_in.sq_root >> 1) + SQRT_BIT;
            end else begin
                work_next.sq_root = work_in.sq_root >> 1;
            end
        end
        if (STEP < CORDIC_STEPS) begin
            if (!work_in.cy[PROD_W-1]) begin
                work_next.cx = work_in.cx + dx;
                work_next.cy = work_in.cy - dy;
                work_next.cz = work_in.cz + dz;
            end else begin
                work_next.cx = work_in.cx - dx;
                work_next.cy = work_in.cy + dy;
                work_next.cz = work_in.cz - dz;
            end
        end
    end

    // Hold on stall, advance otherwise
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= valid_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            work_reg <= work_next;
        end
    end

    assign valid_out = valid_reg;
    assign work_out  = work_reg;

endmodule

/* rtl/complex_arith_unit_core.sv */
// Top level of the complex arithmetic unit: operand register, products, combine,
// iteration chain (cau_iter) and saturating output register. Depends on cau_pkg.
//
// Channel   Dir  Handshake          Payload
// s_        in   s_valid / s_ready  s_data : cau_in_t  (op, a_real, a_imag, b_real, b_imag)
// m_        out  m_valid / m_ready  m_data : cau_out_t (res_real, res_imag, div_zero, overflow)
//
// One item per cycle enters while the pipeline is not held; the stages are the operand, product and combine
// stages, 33 iteration stages set by the 33 quotient bits of the divider, and the output register.
// Reset clears the valid bits only. When m_data is held and m_ready is low the whole
// pipeline holds and s_ready drops; nothing is lost or repeated.
module complex_arith_unit_core
    import cau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  cau_in_t  s_data,
    output logic     m_valid,
    input  logic     m_ready,
    output cau_out_t m_data
);

    localparam logic [PROD_W-1:0] POS_TOP = (PROD_W'(1) << (DATA_WIDTH - 1)) - PROD_W'(1);
    localparam logic [PROD_W-1:0] NEG_TOP = PROD_W'(1) << (DATA_WIDTH - 1);
    localparam logic [PROD_W-1:0] HUGE    = PROD_W'(1) << DATA_WIDTH;

    // Saturate a sign-magnitude value into the word; top bit is the overflow flag
    function automatic logic [DATA_WIDTH:0] sat_pack(input logic neg,
                                                     input logic [PROD_W-1:0] mag_in);
        logic [PROD_W-1:0]     lim;
        logic [PROD_W-1:0]     m;
        logic                  ovf;
        logic [DATA_WIDTH-1:0] v;
        lim = neg ? NEG_TOP : POS_TOP;
        m   = mag_in;
        ovf = 1'b0;
        if (m > lim) begin
            m   = lim;
            ovf = 1'b1;
        end
        v = neg ? (DATA_WIDTH'(0) - m[DATA_WIDTH-1:0]) : m[DATA_WIDTH-1:0];
        return {ovf, v};
    endfunction

    // Saturate a one-bit-wider signed sum
    function automatic logic [DATA_WIDTH:0] sat_sum(input logic signed [DATA_WIDTH:0] s);
        if (s[DATA_WIDTH] != s[DATA_WIDTH-1]) begin
            return {1'b1, s[DATA_WIDTH], {(DATA_WIDTH-1){~s[DATA_WIDTH]}}};
        end
        return {1'b0, s[DATA_WIDTH-1:0]};
    endfunction

    logic en;

    logic    in_valid_reg;
    cau_in_t in_reg;

    logic                         pr_valid_reg;
    logic [2:0]                   pr_op_reg;
    logic signed [DATA_WIDTH-1:0] pr_ar_reg;
    logic signed [DATA_WIDTH-1:0] pr_ai_reg;
    logic                         pr_bzero_reg;
    logic signed [DATA_WIDTH:0]   pr_sum_r_reg;
    logic signed [DATA_WIDTH:0]   pr_sum_i_reg;
    logic signed [PROD_W-1:0]     p_rr_reg;
    logic signed [PROD_W-1:0]     p_ii_reg;
    logic signed [PROD_W-1:0]     p_ri_reg;
    logic signed [PROD_W-1:0]     p_ir_reg;
    logic signed [PROD_W-1:0]     p_br_reg;
    logic signed [PROD_W-1:0]     p_bi_reg;
    logic signed [PROD_W-1:0]     p_ar_reg;
    logic signed [PROD_W-1:0]     p_ai_reg;
    logic signed [DATA_WIDTH:0]   sum_r_next;
    logic signed [DATA_WIDTH:0]   sum_i_next;

    logic                     cb_valid_reg;
    cau_work_t                cb_reg;
    cau_work_t                cb_next;
    logic signed [PROD_W+1:0] acc_x;
    logic signed [PROD_W+1:0] acc_y;
    logic signed [PROD_W+1:0] mag_x;
    logic signed [PROD_W+1:0] mag_y;
    logic [DATA_WIDTH-1:0]    abs_ar;
    logic [DATA_WIDTH-1:0]    abs_ai;

    logic      it_valid [ITER_STEPS+1];
    cau_work_t it_work  [ITER_STEPS+1];

    cau_work_t               wl;
    logic [ANG_W-1:0]        theta;
    logic [ANG_W-1:0]        ang;
    logic [DATA_WIDTH:0]     pk_real;
    logic [DATA_WIDTH:0]     pk_imag;
    logic [PROD_W-1:0]       div_mag_x;
    logic [PROD_W-1:0]       div_mag_y;
    logic                    m_valid_reg;
    cau_out_t                m_data_reg;
    cau_out_t                m_data_next;

    // Whole pipeline moves unless a held result is not taken
    assign en      = !m_valid_reg || m_ready;
    assign s_ready = en;

    // Operand register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_reg <= s_data;
        end
    end

    // Product stage: all cross products and squares, plus the add/sub sums
    always_comb begin
        if (in_reg.op == OP_SUB) begin
            sum_r_next = {in_reg.a_real[DATA_WIDTH-1], in_reg.a_real}
                       - {in_reg.b_real[DATA_WIDTH-1], in_reg.b_real};
            sum_i_next = {in_reg.a_imag[DATA_WIDTH-1], in_reg.a_imag}
                       - {in_reg.b_imag[DATA_WIDTH-1], in_reg.b_imag};
        end else begin
            sum_r_next = {in_reg.a_real[DATA_WIDTH-1], in_reg.a_real}
                       + {in_reg.b_real[DATA_WIDTH-1], in_reg.b_real};
            sum_i_next = {in_reg.a_imag[DATA_WIDTH-1], in_reg.a_imag}
                       + {in_reg.b_imag[DATA_WIDTH-1], in_reg.b_imag};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pr_valid_reg <= 1'b0;
        end else if (en) begin
            pr_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pr_op_reg    <= in_reg.op;
            pr_ar_reg    <= in_reg.a_real;
            pr_ai_reg    <= in_reg.a_imag;
            pr_bzero_reg <= (in_reg.b_real == '0) && (in_reg.b_imag == '0);
            pr_sum_r_reg <= sum_r_next;
            pr_sum_i_reg <= sum_i_next;
            p_rr_reg     <= in_reg.a_real * in_reg.b_real;
            p_ii_reg     <= in_reg.a_imag * in_reg.b_imag;
            p_ri_reg     <= in_reg.a_real * in_reg.b_imag;
            p_ir_reg     <= in_reg.a_imag * in_reg.b_real;
            p_br_reg     <= in_reg.b_real * in_reg.b_real;
            p_bi_reg     <= in_reg.b_imag * in_reg.b_imag;
            p_ar_reg     <= in_reg.a_real * in_reg.a_real;
            p_ai_reg     <= in_reg.a_imag * in_reg.a_imag;
        end
    end

    // Combine stage: real and imaginary sums, divisor, radicand, CORDIC seed
    always_comb begin
        if (pr_op_reg == OP_MUL) begin
            acc_x = (PROD_W+2)'(p_rr_reg) - (PROD_W+2)'(p_ii_reg);
            acc_y = (PROD_W+2)'(p_ri_reg) + (PROD_W+2)'(p_ir_reg);
        end else begin
            acc_x = (PROD_W+2)'(p_rr_reg) + (PROD_W+2)'(p_ii_reg);
            acc_y = (PROD_W+2)'(p_ir_reg) - (PROD_W+2)'(p_ri_reg);
        end
        mag_x  = acc_x[PROD_W+1] ? -acc_x : acc_x;
        mag_y  = acc_y[PROD_W+1] ? -acc_y : acc_y;
        abs_ar = pr_ar_reg[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - pr_ar_reg) : pr_ar_reg;
        abs_ai = pr_ai_reg[DATA_WIDTH-1] ? (DATA_WIDTH'(0) - pr_ai_reg) : pr_ai_reg;

        cb_next          = '0;
        cb_next.op       = pr_op_reg;
        cb_next.sum_real = pr_sum_r_reg;
        cb_next.sum_imag = pr_sum_i_reg;
        cb_next.x_neg    = acc_x[PROD_W+1];
        cb_next.y_neg    = acc_y[PROD_W+1];
        cb_next.x_mag    = mag_x[PROD_W-1:0];
        cb_next.y_mag    = mag_y[PROD_W-1:0];
        cb_next.den      = p_br_reg + p_bi_reg;
        cb_next.div_zero = (pr_op_reg == OP_DIV) && pr_bzero_reg;
        cb_next.sq_rad   = p_ar_reg + p_ai_reg;
        cb_next.cx       = $signed(PROD_W'(abs_ar) << CORDIC_PRESHIFT);
        cb_next.cy       = $signed(PROD_W'(abs_ai) << CORDIC_PRESHIFT);
        cb_next.re_neg   = pr_ar_reg[DATA_WIDTH-1];
        cb_next.im_neg   = pr_ai_reg[DATA_WIDTH-1];
        cb_next.re_zero  = (pr_ar_reg == '0);
        cb_next.im_zero  = (pr_ai_reg == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cb_valid_reg <= 1'b0;
        end else if (en) begin
            cb_valid_reg <= pr_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cb_reg <= cb_next;
        end
    end

    // Iteration chain: divider advances one step per stage; square root and CORDIC in all stages but the last
    assign it_valid[0] = cb_valid_reg;
    assign it_work[0]  = cb_reg;

    for (genvar g = 0; g < ITER_STEPS; g++) begin : g_iter
        cau_iter #(
            .STEP (g)
        ) u_iter (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .valid_in  (it_valid[g]),
            .work_in   (it_work[g]),
            .valid_out (it_valid[g+1]),
            .work_out  (it_work[g+1])
        );
    end

    assign wl = it_work[ITER_STEPS];

    // Angle: clamp, axis cases, then place in its quadrant
    always_comb begin
        if (wl.cz < 0) begin
            theta = '0;
        end else if (wl.cz > $signed(ANG_90)) begin
            theta = ANG_90;
        end else begin
            theta = wl.cz;
        end
        if (wl.re_zero) begin
            theta = ANG_90;
        end else if (wl.im_zero) begin
            theta = '0;
        end
        if (wl.re_zero && wl.im_zero) begin
            ang = '0;
        end else if (!wl.re_neg && !wl.im_neg) begin
            ang = theta;
        end else if (!wl.im_neg) begin
            ang = ANG_180 - theta;
        end else if (wl.re_neg || wl.re_zero) begin
            ang = ANG_180 + theta;
        end else begin
            ang = ANG_360 - theta;
        end
    end

    // Select and saturate the result for the operation
    always_comb begin
        div_mag_x   = wl.x_big ? HUGE : PROD_W'(wl.x_quo);
        div_mag_y   = wl.y_big ? HUGE : PROD_W'(wl.y_quo);
        pk_real     = '0;
        pk_imag     = '0;
        m_data_next = '0;
        case (wl.op)
            OP_ADD, OP_SUB: begin
                pk_real = sat_sum(wl.sum_real);
                pk_imag = sat_sum(wl.sum_imag);
            end
            OP_MUL: begin
                pk_real = sat_pack(wl.x_neg, wl.x_mag >> FRAC_BITS);
                pk_imag = sat_pack(wl.y_neg, wl.y_mag >> FRAC_BITS);
            end
            OP_DIV: begin
                if (!wl.div_zero) begin
                    pk_real = sat_pack(wl.x_neg, div_mag_x);
                    pk_imag = sat_pack(wl.y_neg, div_mag_y);
                end
            end
            OP_POLAR: begin
                pk_real = sat_pack(1'b0, wl.sq_root);
                pk_imag = sat_pack(1'b0, PROD_W'(ang >> (ANG_FRAC - FRAC_BITS)));
            end
            default: begin
                pk_real = '0;
                pk_imag = '0;
            end
        endcase
        m_data_next.res_real = pk_real[DATA_WIDTH-1:0];
        m_data_next.res_imag = pk_imag[DATA_WIDTH-1:0];
        m_data_next.div_zero = wl.div_zero;
        m_data_next.overflow = pk_real[DATA_WIDTH] | pk_imag[DATA_WIDTH];
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= it_valid[ITER_STEPS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule
